// ===== src/mprf_pkg.sv =====
`timescale 1ns / 1ps
package mprf_pkg;

	typedef struct packed {
		logic [1:0] operation;
		logic [7:0] rx_byte;
		logic [5:0] read_index;
	} in_item_t;

	typedef struct packed {
		logic       frame_ready;
		logic       frame_done;
		logic [6:0] fill_position;
		logic [7:0] read_data;
	} out_item_t;

	// operation codes
	localparam logic [1:0] OP_RECEIVE = 2'd0;
	localparam logic [1:0] OP_READ    = 2'd1;
	localparam logic [1:0] OP_CLEAR   = 2'd2;

	// framing codes
	localparam logic [1:0] PROTO_MODBUS = 2'd0;
	localparam logic [1:0] PROTO_HASH   = 2'd1;
	localparam logic [1:0] PROTO_LINE   = 2'd2;
	localparam logic [1:0] PROTO_TILDE  = 2'd3;

	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_TILDE = 8'h7E;

	localparam int TILDE_LEN = 4;

endpackage

// ===== src/mprf_ram.sv =====
`timescale 1ns / 1ps
module mprf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== src/multi_protocol_rx_framer.sv =====
`timescale 1ns / 1ps
// Receive-side frame assembler. Each beat on the input channel carries an
// operation: store a received byte under the framing chosen by the protocol
// register, read one buffer byte, or clear the sticky frame-ready flag.
// Every input beat yields exactly one output beat with the ready flag, a
// frame-done strobe, the fill position after the beat, and the read byte.
// Throughput is one beat per cycle while the receiver takes each output beat,
// set by the single-stage state update and the one write and one read port
// of the buffer RAM. The read byte comes from the RAM's registered output,
// which the RAM holds while the output beat waits. If the receiver stalls
// (out_ready low with out_valid high), in_ready drops and the pending result
// and RAM output hold until taken. Reset clears the fill count, the ready
// flag, the protocol (Modbus ASCII) and all per-entry valid bits, so every
// buffer byte reads as zero; no clearing pass is needed. The buffer clear on
// overflow in the headerless and tilde framings also works by dropping all
// the valid bits together. The user must write the protocol register
// (cfg_wr_en/cfg_wr_data) only while idle; the block does not enforce it.
module multi_protocol_rx_framer #(
	parameter int BUFFER_DEPTH = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [1:0]          cfg_wr_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  mprf_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output mprf_pkg::out_item_t out_data
);

	import mprf_pkg::*;

	localparam int AW = $clog2(BUFFER_DEPTH);
	localparam int CW = $clog2(BUFFER_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(BUFFER_DEPTH);
	localparam logic [CW-1:0] ONE_C   = CW'(1);
	localparam logic [CW-1:0] TWO_C   = CW'(2);
	localparam logic [CW-1:0] TILDE_C = CW'(TILDE_LEN);

	logic [1:0]              protocol_q;
	logic [CW-1:0]           fill_q;
	logic                    ready_q;
	logic [7:0]              first_q;
	logic [7:0]              last_q;
	logic [BUFFER_DEPTH-1:0] valid_q;

	logic                    v_s1;
	logic                    ready_s1;
	logic                    done_s1;
	logic [6:0]              fill_s1;
	logic                    rd_hit_s1;

	logic                    accept;
	logic                    is_rx;
	logic [7:0]              b;
	logic [7:0]              start_byte;
	logic                    stored;
	logic                    at_zero;
	logic                    clr_ready;
	logic                    clear_on_full;
	logic                    done;
	logic                    term;
	logic                    clear_all;
	logic [CW-1:0]           fill_inc;
	logic [CW-1:0]           cnt;
	logic [7:0]              first_cur;
	logic [CW-1:0]           fill_next;
	logic                    ready_next;
	logic [BUFFER_DEPTH-1:0] valid_next;
	logic [AW-1:0]           wpos;
	logic [AW-1:0]           tpos;
	logic [AW+5:0]           idx_ext;
	logic [AW-1:0]           raddr;
	logic                    rd_in_range;
	logic [7:0]              ram_rdata;

	assign in_ready = !v_s1 || out_ready;
	assign accept   = in_valid && in_ready;
	assign is_rx    = in_data.operation == OP_RECEIVE;
	assign b        = in_data.rx_byte;
	assign fill_inc = fill_q + ONE_C;

	always_comb begin
		stored        = 1'b0;
		at_zero       = 1'b0;
		clr_ready     = 1'b0;
		clear_on_full = 1'b0;
		done          = 1'b0;
		term          = 1'b0;
		cnt           = fill_q;
		start_byte    = (protocol_q == PROTO_MODBUS) ? CH_COLON : CH_HASH;
		unique case (protocol_q)
			PROTO_MODBUS, PROTO_HASH: begin
				// a start byte restarts the frame even mid-frame
				if (b == start_byte) begin
					stored    = 1'b1;
					at_zero   = 1'b1;
					clr_ready = 1'b1;
					cnt       = ONE_C;
				end else if (fill_q != '0) begin
					stored = 1'b1;
					cnt    = fill_inc;
				end
			end
			PROTO_LINE: begin
				clear_on_full = 1'b1;
				if (b != CH_GT && b != CH_LF) begin
					stored    = 1'b1;
					at_zero   = fill_q == '0;
					clr_ready = 1'b1;
					cnt       = fill_inc;
				end
			end
			PROTO_TILDE: begin
				clear_on_full = 1'b1;
				if (b == CH_TILDE && fill_q == '0) begin
					stored    = 1'b1;
					at_zero   = 1'b1;
					clr_ready = 1'b1;
					cnt       = fill_inc;
				end else if (fill_q != '0 && fill_q < TILDE_C) begin
					stored    = 1'b1;
					clr_ready = 1'b1;
					cnt       = fill_inc;
				end
			end
			default: begin
				stored = 1'b0;
			end
		endcase

		// position 0 of this frame; last_q is the byte just before this one
		first_cur = at_zero ? b : first_q;

		if (stored) begin
			unique case (protocol_q)
				PROTO_MODBUS: done = first_cur == CH_COLON && cnt >= TWO_C &&
					last_q == CH_CR && b == CH_LF;
				PROTO_HASH:   done = first_cur == CH_HASH && b == CH_CR;
				PROTO_LINE:   done = b == CH_CR;
				PROTO_TILDE:  done = first_cur == CH_TILDE && cnt == TILDE_C;
				default:      done = 1'b0;
			endcase
		end
		// zero terminator after CR, done by dropping the entry's valid bit
		term = done && protocol_q == PROTO_LINE && cnt < DEPTH_C;
	end

	always_comb begin
		fill_next  = fill_q;
		ready_next = ready_q;
		clear_all  = 1'b0;
		unique case (in_data.operation)
			OP_RECEIVE: begin
				if (stored) begin
					if (done) begin
						ready_next = 1'b1;
						fill_next  = '0;
					end else if (cnt >= DEPTH_C) begin
						ready_next = 1'b0;
						fill_next  = '0;
						clear_all  = clear_on_full;
					end else begin
						fill_next  = cnt;
						ready_next = clr_ready ? 1'b0 : ready_q;
					end
				end
			end
			OP_CLEAR: ready_next = 1'b0;
			default:  ready_next = ready_q;
		endcase
	end

	always_comb begin
		valid_next = valid_q;
		if (is_rx && stored) begin
			if (clear_all) begin
				valid_next = '0;
			end else begin
				valid_next[wpos] = 1'b1;
				if (term) begin
					valid_next[tpos] = 1'b0;
				end
			end
		end
	end

	assign wpos        = at_zero ? '0 : fill_q[AW-1:0];
	assign tpos        = cnt[AW-1:0];
	assign idx_ext     = (AW + 6)'(in_data.read_index);
	assign raddr       = idx_ext[AW-1:0];
	assign rd_in_range = 32'(in_data.read_index) < BUFFER_DEPTH;

	mprf_ram #(
		.WIDTH (8),
		.DEPTH (BUFFER_DEPTH)
	) u_buf (
		.clk   (clk),
		.we    (accept && is_rx && stored),
		.waddr (wpos),
		.wdata (b),
		.re    (accept && in_data.operation == OP_READ),
		.raddr (raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			protocol_q <= PROTO_MODBUS;
		end else if (cfg_wr_en) begin
			protocol_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			ready_q <= 1'b0;
			valid_q <= '0;
		end else if (accept) begin
			fill_q  <= fill_next;
			ready_q <= ready_next;
			valid_q <= valid_next;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_rx && stored) begin
			last_q <= b;
			if (at_zero) begin
				first_q <= b;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ready_s1  <= ready_next;
			done_s1   <= is_rx && done;
			fill_s1   <= 7'(fill_next);
			rd_hit_s1 <= in_data.operation == OP_READ && rd_in_range && valid_q[raddr];
		end
	end

	assign out_valid              = v_s1;
	assign out_data.frame_ready   = ready_s1;
	assign out_data.frame_done    = done_s1;
	assign out_data.fill_position = fill_s1;
	assign out_data.read_data     = rd_hit_s1 ? ram_rdata : 8'h00;

	a_fill_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q < DEPTH_C)
		else $error("fill count reached buffer depth");

	a_done_resets_fill: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.frame_done |->
			out_data.frame_ready && out_data.fill_position == 7'd0)
		else $error("frame done without ready flag or with nonzero fill");

	a_non_rx_keeps_fill: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !is_rx |=> fill_q == $past(fill_q))
		else $error("fill count moved on a non-receive beat");

	a_clear_drops_ready: assert property (@(posedge clk) disable iff (!arst_n)
		accept && in_data.operation == OP_CLEAR |=> !ready_q && !out_data.frame_ready)
		else $error("ready flag survived a clear beat");

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
	import mprf_pkg::*;

	localparam int MSG_DEPTH = 64;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef struct {
		bit         cfg;
		logic [1:0] proto;
		in_item_t   beat;
		bit         known;
		out_item_t  want;
	} plan_row_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      cfg_wr_en = 1'b0;
	logic [1:0] cfg_wr_data = '0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_item_t  in_data = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_data;

	// framer shadow state
	logic [7:0] msg_mem [MSG_DEPTH];
	int         fill_cnt;
	bit         ready_m;
	logic [1:0] proto_sel;

	out_item_t  due_results [$];
	plan_row_t  plan [$];
	int         miss_cnt = 0;
	int         beats_in = 0;
	int         beats_out = 0;
	int         stall_left = 0;
	bit         calm = 1'b0;
	out_item_t  due;

	multi_protocol_rx_framer #(.BUFFER_DEPTH(MSG_DEPTH)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [7:0] peek(int pos);
		return (pos >= 0 && pos < MSG_DEPTH) ? msg_mem[pos] : 8'h00;
	endfunction

	function automatic void put(logic [7:0] b);
		if (fill_cnt < MSG_DEPTH) begin
			msg_mem[fill_cnt] = b;
			fill_cnt++;
		end
	endfunction

	// returns 1 when this byte closes a frame
	function automatic bit take_rx_byte(logic [7:0] b);
		bit stored;
		bit done;
		bit wipe;
		logic [7:0] start;
		stored = 1'b0;
		done = 1'b0;
		wipe = 1'b0;
		case (proto_sel)
			PROTO_MODBUS, PROTO_HASH: begin
				start = (proto_sel == PROTO_MODBUS) ? CH_COLON : CH_HASH;
				if (b == start) begin
					msg_mem[0] = start;
					fill_cnt = 1;
					ready_m = 1'b0;
					stored = 1'b1;
				end else if (fill_cnt != 0) begin
					put(b);
					stored = 1'b1;
				end
				if (stored) begin
					if (proto_sel == PROTO_MODBUS)
						done = peek(0) == CH_COLON && fill_cnt >= 2 &&
							peek(fill_cnt - 2) == CH_CR && peek(fill_cnt - 1) == CH_LF;
					else
						done = peek(0) == CH_HASH && peek(fill_cnt - 1) == CH_CR;
				end
			end
			PROTO_LINE: begin
				wipe = 1'b1;
				if (b != CH_GT && b != CH_LF) begin
					put(b);
					ready_m = 1'b0;
					stored = 1'b1;
				end
				if (stored && fill_cnt >= 1 && peek(fill_cnt - 1) == CH_CR) begin
					done = 1'b1;
					// zero terminator after the CR
					if (fill_cnt < MSG_DEPTH)
						msg_mem[fill_cnt] = 8'h00;
				end
			end
			PROTO_TILDE: begin
				wipe = 1'b1;
				if (b == CH_TILDE && fill_cnt == 0) begin
					ready_m = 1'b0;
					put(b);
					stored = 1'b1;
				end else if (fill_cnt > 0 && fill_cnt < TILDE_LEN) begin
					put(b);
					ready_m = 1'b0;
					stored = 1'b1;
				end
				if (stored)
					done = peek(0) == CH_TILDE && fill_cnt == TILDE_LEN;
			end
		endcase
		if (!stored)
			return 1'b0;
		if (done) begin
			ready_m = 1'b1;
			fill_cnt = 0;
			return 1'b1;
		end
		if (fill_cnt >= MSG_DEPTH) begin
			if (wipe)
				foreach (msg_mem[i]) msg_mem[i] = 8'h00;
			fill_cnt = 0;
			ready_m = 1'b0;
		end
		return 1'b0;
	endfunction

	function automatic out_item_t framer_step(in_item_t it);
		out_item_t r;
		r = '0;
		case (it.operation)
			OP_RECEIVE: r.frame_done = take_rx_byte(it.rx_byte);
			OP_READ:    r.read_data = peek(int'(it.read_index));
			OP_CLEAR:   ready_m = 1'b0;
			default: ;
		endcase
		r.frame_ready = ready_m;
		r.fill_position = 7'(fill_cnt);
		return r;
	endfunction

	// mostly short idles, now and then a long one
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 2);
		else if (r < 95)
			return $urandom_range(3, 6);
		return $urandom_range(10, 24);
	endfunction

	function automatic int pick_gap();
		if (calm || $urandom_range(0, 99) < 55)
			return 0;
		return idle_len();
	endfunction

	task automatic log_miss(string what, int got, int want);
		miss_cnt++;
		if (miss_cnt <= 40)
			$display("%0t result beat %0d: %s got 0x%0h, want 0x%0h",
				$time, beats_out, what, got, want);
	endtask

	task automatic push_beat(in_item_t it, bit known, out_item_t want);
		int gap;
		out_item_t guess;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		guess = framer_step(it);
		due_results.push_back(known ? want : guess);
		beats_in++;
	endtask

	task automatic feed(logic [7:0] b);
		in_item_t it;
		it.operation = OP_RECEIVE;
		it.rx_byte = b;
		it.read_index = 6'($urandom);
		push_beat(it, 1'b0, '0);
	endtask

	task automatic ctl_beat(logic [1:0] op);
		in_item_t it;
		it.operation = op;
		it.rx_byte = 8'($urandom);
		it.read_index = $urandom_range(0, 1) ? 6'($urandom) : 6'($urandom_range(0, 7));
		push_beat(it, 1'b0, '0);
	endtask

	task automatic set_protocol(logic [1:0] p);
		in_valid <= 1'b0;
		while (due_results.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= p;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		proto_sel = p;
	endtask

	function automatic logic [7:0] frame_byte();
		if ($urandom_range(0, 99) >= 6)
			return 8'($urandom);
		case ($urandom_range(0, 5))
			0: return CH_CR;
			1: return CH_LF;
			2: return CH_COLON;
			3: return CH_HASH;
			4: return CH_GT;
			default: return CH_TILDE;
		endcase
	endfunction

	// one frame in the current framing; broken ones lose or garble the end
	task automatic send_frame(bit broken);
		int len;
		len = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 8) : $urandom_range(40, 70);
		case (proto_sel)
			PROTO_MODBUS: begin
				feed(CH_COLON);
				repeat (len) feed(frame_byte());
				if (broken) begin
					if ($urandom_range(0, 1))
						feed(CH_LF);
					feed(CH_CR);
				end else begin
					feed(CH_CR);
					feed(CH_LF);
				end
			end
			PROTO_HASH: begin
				feed(CH_HASH);
				repeat (len) feed(frame_byte());
				if (!broken)
					feed(CH_CR);
			end
			PROTO_LINE: begin
				repeat (len) feed(frame_byte());
				if (!broken)
					feed(CH_CR);
			end
			PROTO_TILDE: begin
				feed(CH_TILDE);
				repeat (broken ? $urandom_range(0, 2) : TILDE_LEN - 1) feed(frame_byte());
			end
		endcase
	endtask

	always @(posedge clk) begin
		if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			out_ready <= 1'b1;
			if (!calm && $urandom_range(0, 99) < 25)
				stall_left <= idle_len();
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (due_results.size() == 0) begin
				log_miss("unexpected beat", int'(out_data), 0);
			end else begin
				due = due_results.pop_front();
				if (out_data.frame_ready !== due.frame_ready)
					log_miss("frame_ready", out_data.frame_ready, due.frame_ready);
				if (out_data.frame_done !== due.frame_done)
					log_miss("frame_done", out_data.frame_done, due.frame_done);
				if (out_data.fill_position !== due.fill_position)
					log_miss("fill_position", out_data.fill_position, due.fill_position);
				if (out_data.read_data !== due.read_data)
					log_miss("read_data", out_data.read_data, due.read_data);
			end
			beats_out++;
		end
	end

	initial begin
		logic [1:0] phase_proto [8];
		int phase_end;
		int r;
		phase_proto = '{PROTO_MODBUS, PROTO_HASH, PROTO_LINE, PROTO_TILDE,
			PROTO_TILDE, PROTO_MODBUS, PROTO_LINE, PROTO_HASH};
		foreach (msg_mem[i]) msg_mem[i] = 8'h00;
		fill_cnt = 0;
		ready_m = 1'b0;
		proto_sel = PROTO_MODBUS;

		// Modbus ASCII, straight out of reset
		plan.push_back('{1'b0, '0, '{OP_READ, 8'h00, 6'd63}, 1'b1, '{1'b0, 1'b0, 7'd0, 8'h00}});
		plan.push_back('{1'b0, '0, '{OP_RECEIVE, 8'h41, 6'd0}, 1'b1, '{1'b0, 1'b0, 7'd0, 8'h00}});
		plan.push_back('{1'b0, '0, '{OP_RECEIVE, CH_COLON, 6'd0}, 1'b1, '{1'b0, 1'b0, 7'd1, 8'h00}});
		plan.push_back('{1'b0, '0, '{OP_RECEIVE, CH_CR, 6'd0}, 1'b1, '{1'b0, 1'b0, 7'd2, 8'h00}});
		plan.push_back('{1'b0, '0, '{OP_RECEIVE, CH_LF, 6'd0}, 1'b1, '{1'b1, 1'b1, 7'd0, 8'h00}});
		plan.push_back('{1'b0, '0, '{OP_READ, 8'hFF, 6'd0}, 1'b1, '{1'b1, 1'b0, 7'd0, CH_COLON}});
		plan.push_back('{1'b0, '0, '{OP_UNUSED, 8'hFF, 6'd63}, 1'b1, '{1'b1, 1'b0, 7'd0, 8'h00}});
		plan.push_back('{1'b0, '0, '{OP_CLEAR, 8'h00, 6'd0}, 1'b1, '{1'b0, 1'b0, 7'd0, 8'h00}});
		plan.push_back('{1'b0, '0, '{OP_RECEIVE, CH_COLON, 6'd5}, 1'b0, '0});
		plan.push_back('{1'b0, '0, '{OP_RECEIVE, 8'hFF, 6'd0}, 1'b0, '0});
		// start byte mid-frame restarts it
		plan.push_back('{1'b0, '0, '{OP_RECEIVE, CH_COLON, 6'd0}, 1'b0, '0});
		// hash framing; the open Modbus frame carries over
		plan.push_back('{1'b1, PROTO_HASH, '0, 1'b0, '0});
		plan.push_back('{1'b0, '0, '{OP_RECEIVE, 8'h00, 6'd0}, 1'b0, '0});
		plan.push_back('{1'b0, '0, '{OP_RECEIVE, CH_HASH, 6'd0}, 1'b1, '{1'b0, 1'b0, 7'd1, 8'h00}});
		plan.push_back('{1'b0, '0, '{OP_RECEIVE, CH_CR, 6'd0}, 1'b1, '{1'b1, 1'b1, 7'd0, 8'h00}});
		// headerless line: '>' and LF dropped, zero written after CR
		plan.push_back('{1'b1, PROTO_LINE, '0, 1'b0, '0});
		plan.push_back('{1'b0, '0, '{OP_RECEIVE, CH_GT, 6'd0}, 1'b1, '{1'b1, 1'b0, 7'd0, 8'h00}});
		plan.push_back('{1'b0, '0, '{OP_RECEIVE, CH_LF, 6'd0}, 1'b1, '{1'b1, 1'b0, 7'd0, 8'h00}});
		plan.push_back('{1'b0, '0, '{OP_RECEIVE, 8'h78, 6'd0}, 1'b1, '{1'b0, 1'b0, 7'd1, 8'h00}});
		plan.push_back('{1'b0, '0, '{OP_RECEIVE, CH_CR, 6'd0}, 1'b1, '{1'b1, 1'b1, 7'd0, 8'h00}});
		plan.push_back('{1'b0, '0, '{OP_READ, 8'h00, 6'd2}, 1'b1, '{1'b1, 1'b0, 7'd0, 8'h00}});
		plan.push_back('{1'b0, '0, '{OP_READ, 8'h00, 6'd1}, 1'b1, '{1'b1, 1'b0, 7'd0, CH_CR}});
		// tilde: four fixed bytes, strays ignored
		plan.push_back('{1'b1, PROTO_TILDE, '0, 1'b0, '0});
		plan.push_back('{1'b0, '0, '{OP_RECEIVE, 8'h61, 6'd0}, 1'b1, '{1'b1, 1'b0, 7'd0, 8'h00}});
		plan.push_back('{1'b0, '0, '{OP_RECEIVE, CH_TILDE, 6'd0}, 1'b1, '{1'b0, 1'b0, 7'd1, 8'h00}});
		plan.push_back('{1'b0, '0, '{OP_RECEIVE, 8'h00, 6'd0}, 1'b0, '0});
		plan.push_back('{1'b0, '0, '{OP_RECEIVE, 8'hFF, 6'd0}, 1'b0, '0});
		plan.push_back('{1'b0, '0, '{OP_RECEIVE, CH_CR, 6'd0}, 1'b1, '{1'b1, 1'b1, 7'd0, 8'h00}});
		plan.push_back('{1'b0, '0, '{OP_RECEIVE, 8'h55, 6'd0}, 1'b1, '{1'b1, 1'b0, 7'd0, 8'h00}});
		plan.push_back('{1'b0, '0, '{OP_READ, 8'h00, 6'd3}, 1'b1, '{1'b1, 1'b0, 7'd0, CH_CR}});

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].cfg)
				set_protocol(plan[i].proto);
			else
				push_beat(plan[i].beat, plan[i].known, plan[i].want);
		end

		foreach (phase_proto[p]) begin
			set_protocol(phase_proto[p]);
			calm = (p == 2 || p == 5);
			phase_end = beats_in + 172;
			while (beats_in < phase_end) begin
				r = $urandom_range(0, 99);
				if (r < 55)
					send_frame(1'b0);
				else if (r < 65)
					send_frame(1'b1);
				else if (r < 77)
					ctl_beat(OP_READ);
				else if (r < 82)
					ctl_beat(OP_CLEAR);
				else if (r < 85)
					ctl_beat(OP_UNUSED);
				else
					feed(8'($urandom));
			end
			// leave a closed frame behind before the framing changes
			send_frame(1'b0);
		end
		calm = 1'b0;
		in_valid <= 1'b0;

		for (int w = 0; w < 2000 && due_results.size() != 0; w++)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (miss_cnt == 0 && due_results.size() == 0)
			$display("multi_protocol_rx_framer: match");
		else
			$display("multi_protocol_rx_framer: mismatch");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("multi_protocol_rx_framer: mismatch");
		$finish;
	end

endmodule
